// ===== hw/rtl/nearest_point_snap_table_assert.svh =====
// Assertion macros for the snap table
`ifndef NEAREST_POINT_SNAP_TABLE_ASSERT_SVH
`define NEAREST_POINT_SNAP_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NPST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NPST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/npst_pkg.sv =====
package npst_pkg;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned DIST_W = 31;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [2:0] REG_SNAP_DIST = 3'd0;
    localparam logic [2:0] REG_PERIOD    = 3'd1;
    localparam logic [2:0] REG_KF_MODE   = 3'd2;
    localparam logic [2:0] REG_BAR_START = 3'd3;
    localparam logic [2:0] REG_BAR_END   = 3'd4;
    localparam logic [2:0] REG_KF_RANGE  = 3'd5;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] time_value;
        logic              snap_on;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_time;
        logic              snapped;
        logic              table_full;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_SHIFT,
        ST_ADD_PUT,
        ST_Q_SCAN,
        ST_Q_DIV,
        ST_Q_PER,
        ST_Q_FIN,
        ST_OUT
    } t_state;

    // request from sequencer to divider
    typedef struct packed {
        logic        start;
        logic signed [31:0] dividend;
        logic [30:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic signed [32:0] quot;
    } t_div_rsp;

    function automatic logic [33:0] abs_diff(input logic signed [33:0] a,
                                             input logic signed [33:0] b);
        logic signed [34:0] d;
        d = 35'(a) - 35'(b);
        abs_diff = d[34] ? 34'(-d) : 34'(d);
    endfunction
endpackage

// ===== hw/rtl/nearest_point_snap_table.sv =====
// Sorted snap-point table with snap query. Add: scan the entries below the new time,
// shift each later entry up one slot, then write the new time. Query with snapping on:
// scan the entries, run the divider, pick the nearer periodic point, then compare with
// the snap distance; snapping off: final compare; clear or unused command: output only.
// One request at a time; the next is taken only after the result is loaded.
// Synchronous active-low reset empties the table and restores register defaults.
`include "nearest_point_snap_table_assert.svh"
module nearest_point_snap_table
    import npst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [30:0] r_snap_distance, r_periodic_interval, r_keyframe_range;
    logic        r_keyframe_mode;
    logic signed [31:0] r_bar_start_time, r_bar_end_time;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic busy;
    logic [2:0] reg_idx;
    logic wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_distance     <= '0;
            r_periodic_interval <= 31'h7FFFFFFF;
            r_keyframe_mode     <= 1'b0;
            r_bar_start_time    <= '0;
            r_bar_end_time      <= '0;
            r_keyframe_range    <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_SNAP_DIST: r_snap_distance     <= pwdata[30:0];
                REG_PERIOD:    r_periodic_interval <= pwdata[30:0];
                REG_KF_MODE:   r_keyframe_mode     <= pwdata[0];
                REG_BAR_START: r_bar_start_time    <= pwdata;
                REG_BAR_END:   r_bar_end_time      <= pwdata;
                REG_KF_RANGE:  r_keyframe_range    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SNAP_DIST: prdata = {1'b0, r_snap_distance};
            REG_PERIOD:    prdata = {1'b0, r_periodic_interval};
            REG_KF_MODE:   prdata = {31'b0, r_keyframe_mode};
            REG_BAR_START: prdata = r_bar_start_time;
            REG_BAR_END:   prdata = r_bar_end_time;
            REG_KF_RANGE:  prdata = {1'b0, r_keyframe_range};
            default:       prdata = '0;
        endcase
    end

    npst_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    npst_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_data          (i_in_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_data         (o_out_data),
        .i_snap_distance    (r_snap_distance),
        .i_periodic_interval(r_periodic_interval),
        .i_keyframe_mode    (r_keyframe_mode),
        .i_bar_start_time   (r_bar_start_time),
        .i_bar_end_time     (r_bar_end_time),
        .i_keyframe_range   (r_keyframe_range),
        .o_div_req          (div_req),
        .i_div_rsp          (div_rsp),
        .o_busy             (busy)
    );

    `NPST_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, busy, o_in_stall)
    `NPST_ASSERT_IMPL(a_full_only_add, i_clk, i_rst_n,
        o_out_valid && o_out_data.table_full, !o_out_data.snapped)
    `NPST_ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, div_req.start, busy)
endmodule

// ===== hw/rtl/npst_div.sv =====
module npst_div
    import npst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_mag, n_mag;
    logic [30:0] r_dsr, n_dsr;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_mag  = r_mag;
        n_dsr  = r_dsr;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_mag[31]} - {2'b0, r_dsr};
        if (i_req.start) begin
            n_mag  = i_req.dividend[31] ? 32'(-i_req.dividend) : 32'(i_req.dividend);
            n_dsr  = (i_req.divisor == '0) ? 31'd1 : i_req.divisor;
            n_neg  = i_req.dividend[31];
            n_rem  = '0;
            n_quo  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // one quotient bit per cycle
            n_mag = {r_mag[30:0], 1'b0};
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_mag[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_mag <= n_mag;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule

// ===== hw/rtl/npst_seq.sv =====
module npst_seq
    import npst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic [30:0] i_snap_distance,
    input  logic [30:0] i_periodic_interval,
    input  logic        i_keyframe_mode,
    input  logic signed [31:0] i_bar_start_time,
    input  logic signed [31:0] i_bar_end_time,
    input  logic [30:0] i_keyframe_range,
    output t_div_req    o_div_req,
    input  t_div_rsp    i_div_rsp,
    output logic        o_busy
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic signed [31:0] mem [TABLE_DEPTH];
    logic signed [31:0] r_rd;

    t_state r_state, n_state;
    t_in_item r_req;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_rd_ok, n_rd_ok;
    logic signed [31:0] r_prev, n_prev, r_next, n_next;
    logic signed [33:0] r_best, n_best;
    logic signed [33:0] r_per, n_per;
    t_out_item r_res, n_res;
    t_out_item r_out, n_out;
    logic r_ov, n_ov;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic signed [31:0] mem_wd;
    logic [AW-1:0] mem_ra;

    logic signed [33:0] q_w, lo_w, hi_w, p_w, cand, t_w;
    logic [33:0] d_a, d_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_busy     = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign q_w = 34'(r_req.time_value);
    assign p_w = 34'({1'b0, (i_periodic_interval == '0) ? 31'd1 : i_periodic_interval});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd'(i_in_data.command))
                        CMD_ADD:   n_state = ST_ADD_SCAN;
                        CMD_QUERY: n_state = i_in_data.snap_on ? ST_Q_SCAN : ST_Q_FIN;
                        CMD_CLEAR, CMD_NONE: n_state = ST_OUT;
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                if (r_rd_ok) begin
                    if (r_rd == r_req.time_value) begin
                        n_state = ST_OUT;
                    end else if (r_rd > r_req.time_value) begin
                        n_state = (r_cnt >= CW'(TABLE_DEPTH)) ? ST_OUT : ST_ADD_SHIFT;
                    end
                end else if (r_idx >= r_cnt) begin
                    n_state = (r_cnt >= CW'(TABLE_DEPTH)) ? ST_OUT : ST_ADD_SHIFT;
                end
            end
            ST_ADD_SHIFT: if (r_idx == r_pos && !r_rd_ok) n_state = ST_ADD_PUT;
            ST_ADD_PUT:   n_state = ST_OUT;
            ST_Q_SCAN: begin
                if (r_rd_ok) begin
                    if (r_rd >= r_req.time_value || r_idx >= r_cnt) n_state = ST_Q_DIV;
                end else if (r_idx >= r_cnt) begin
                    n_state = ST_Q_DIV;
                end
            end
            ST_Q_DIV: if (i_div_rsp.done) n_state = ST_Q_PER;
            ST_Q_PER: n_state = ST_Q_FIN;
            ST_Q_FIN: n_state = ST_OUT;
            ST_OUT:   if (!r_ov || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_rd_ok = 1'b0;
        n_prev  = r_prev;
        n_next  = r_next;
        n_best  = r_best;
        n_per   = r_per;
        n_res   = r_res;
        n_out   = r_out;
        n_ov    = r_ov && i_out_stall;
        mem_we  = 1'b0;
        mem_wa  = r_idx[AW-1:0];
        mem_wd  = r_rd;
        mem_ra  = r_idx[AW-1:0];
        lo_w    = '0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_req.time_value;
        o_div_req.divisor  = i_periodic_interval;
        cand = '0;
        t_w  = '0;
        d_a  = '0;
        d_b  = '0;
        hi_w = '0;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_prev = '0;
                n_next = '0;
                mem_ra = '0;
                if (i_in_valid) begin
                    n_res = '0;
                    if (t_cmd'(i_in_data.command) == CMD_CLEAR) n_cnt = '0;
                    n_rd_ok = (r_cnt != '0) &&
                              (t_cmd'(i_in_data.command) == CMD_ADD ||
                               t_cmd'(i_in_data.command) == CMD_QUERY);
                    if (r_cnt != '0) n_idx = CW'(1);
                end
            end
            ST_ADD_SCAN: begin
                mem_ra = r_idx[AW-1:0];
                if (r_rd_ok) begin
                    if (r_rd == r_req.time_value) begin
                        n_idx = '0;
                    end else if (r_rd > r_req.time_value) begin
                        n_pos = r_idx - CW'(1);
                        if (r_cnt >= CW'(TABLE_DEPTH)) n_res.table_full = 1'b1;
                        n_idx = r_cnt;
                    end else begin
                        n_rd_ok = (r_idx < r_cnt);
                        if (r_idx < r_cnt) n_idx = r_idx + CW'(1);
                    end
                end else begin
                    n_pos = r_cnt;
                    if (r_cnt >= CW'(TABLE_DEPTH)) n_res.table_full = 1'b1;
                    n_idx = r_cnt;
                end
            end
            ST_ADD_SHIFT: begin
                // move entry idx-1 up to idx: read it first, then write it
                if (r_idx != r_pos) begin
                    if (!r_rd_ok) begin
                        mem_ra = AW'(r_idx - CW'(1));
                        n_rd_ok = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_idx[AW-1:0];
                        mem_wd = r_rd;
                        n_idx = r_idx - CW'(1);
                    end
                end
            end
            ST_ADD_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_pos[AW-1:0];
                mem_wd = r_req.time_value;
                n_cnt = r_cnt + CW'(1);
            end
            ST_Q_SCAN: begin
                mem_ra = r_idx[AW-1:0];
                if (r_rd_ok) begin
                    n_prev = r_next;
                    n_next = r_rd;
                    if (!(r_rd >= r_req.time_value) && r_idx < r_cnt) begin
                        n_rd_ok = 1'b1;
                        n_idx = r_idx + CW'(1);
                    end
                end
                if (n_state == ST_Q_DIV) o_div_req.start = 1'b1;
            end
            ST_Q_DIV: begin
                d_a = abs_diff(34'(r_prev), q_w);
                d_b = abs_diff(34'(r_next), q_w);
                n_best = (d_a <= d_b) ? 34'(r_prev) : 34'(r_next);
                n_per = 34'(i_div_rsp.quot);
            end
            ST_Q_PER: begin
                // quotient * interval; pick nearest periodic or table point
                lo_w = 34'($signed(r_per[32:0]) * $signed({1'b0, p_w[31:0]}));
                hi_w = lo_w + p_w;
                d_a = abs_diff(lo_w, q_w);
                d_b = abs_diff(hi_w, q_w);
                t_w = (d_a <= d_b) ? lo_w : hi_w;
                d_a = abs_diff(r_best, q_w);
                d_b = abs_diff(t_w, q_w);
                n_best = (d_a <= d_b) ? r_best : t_w;
            end
            ST_Q_FIN: begin
                n_res.result_time = r_req.time_value;
                if (r_req.snap_on) begin
                    cand = r_best;
                    d_a = abs_diff(cand, q_w);
                    if (d_a <= 34'(i_snap_distance)) begin
                        n_res.snapped = 1'b1;
                        n_res.result_time = (cand > 34'sd2147483647) ?
                            32'sh7FFFFFFF : cand[31:0];
                    end
                end else if (i_keyframe_mode) begin
                    d_a = abs_diff(34'(i_bar_start_time), q_w);
                    d_b = abs_diff(34'(i_bar_end_time), q_w);
                    cand = (d_a <= d_b) ? 34'(i_bar_start_time) : 34'(i_bar_end_time);
                    t_w = (d_a <= d_b) ? 34'(d_a) : 34'(d_b);
                    if (t_w[33:0] <= 34'(i_keyframe_range)) begin
                        n_res.snapped = 1'b1;
                        n_res.result_time = cand[31:0];
                    end
                end
            end
            ST_OUT: begin
                // load the output register once it is free
                if (!r_ov || !i_out_stall) begin
                    n_ov  = 1'b1;
                    n_out = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_rd_ok <= n_rd_ok;
        end
        if (r_state == ST_IDLE && i_in_valid) r_req <= i_in_data;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_prev <= n_prev;
        r_next <= n_next;
        r_best <= n_best;
        r_per  <= n_per;
        r_res  <= n_res;
        r_out  <= n_out;
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import npst_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam longint TIME_MAX = 64'sd2147483647;
    localparam int CYCLE_LIMIT = 1200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_point_snap_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint     snap_times[$];
    longint     cfg_snap_dist;
    longint     cfg_period;
    bit         cfg_kf_mode;
    longint     cfg_bar_start;
    longint     cfg_bar_end;
    longint     cfg_kf_range;
    t_out_item  pending_results[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  queries_sent = 0;
    int  snaps_seen = 0;
    int  drops_seen = 0;
    int  cycles = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint nearer(longint a, longint b, longint q);
        return (mag(a - q) <= mag(b - q)) ? a : b;
    endfunction

    function automatic t_out_item predict_snap(t_in_item it);
        t_out_item r;
        longint q, prev, next, best, p, lo, hi;
        int pos;
        r = '0;
        q = longint'(it.time_value);
        case (t_cmd'(it.command))
            CMD_ADD: begin
                pos = 0;
                while (pos < snap_times.size() && snap_times[pos] < q) pos++;
                if (!(pos < snap_times.size() && snap_times[pos] == q)) begin
                    if (snap_times.size() >= TABLE_DEPTH) r.table_full = 1'b1;
                    else snap_times.insert(pos, q);
                end
            end
            CMD_CLEAR: snap_times.delete();
            CMD_QUERY: begin
                best = q;
                if (it.snap_on) begin
                    prev = 0;
                    next = 0;
                    foreach (snap_times[i]) begin
                        prev = next;
                        next = snap_times[i];
                        if (next >= q) break;
                    end
                    best = nearer(prev, next, q);
                    p = (cfg_period == 0) ? 1 : cfg_period;
                    lo = q / p * p;
                    hi = (q / p + 1) * p;
                    best = nearer(best, nearer(lo, hi, q), q);
                    if (mag(best - q) <= cfg_snap_dist) r.snapped = 1'b1;
                    else best = q;
                end else if (cfg_kf_mode) begin
                    best = nearer(cfg_bar_start, cfg_bar_end, q);
                    if (mag(best - q) <= cfg_kf_range) r.snapped = 1'b1;
                    else best = q;
                end
                if (best > TIME_MAX) best = TIME_MAX;
                r.result_time = best[31:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // check results
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out_data.result_time !== exp_r.result_time ||
                    o_out_data.snapped !== exp_r.snapped ||
                    o_out_data.table_full !== exp_r.table_full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp time=%0d snap=%b full=%b got time=%0d snap=%b full=%b",
                                 exp_r.result_time, exp_r.snapped, exp_r.table_full,
                                 o_out_data.result_time, o_out_data.snapped,
                                 o_out_data.table_full);
                end
                if (exp_r.snapped) snaps_seen++;
                if (exp_r.table_full) drops_seen++;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic send_request(t_cmd cmd, logic [31:0] t, logic on);
        t_in_item it;
        it.command = cmd;
        it.time_value = t;
        it.snap_on = on;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.insert(pending_results.size(), predict_snap(it));
        if (cmd == CMD_QUERY) queries_sent++;
        // valid stays up until the next request or drain; the block stalls meanwhile
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        case (idx)
            REG_SNAP_DIST: cfg_snap_dist = longint'(v[30:0]);
            REG_PERIOD:    cfg_period = longint'(v[30:0]);
            REG_KF_MODE:   cfg_kf_mode = v[0];
            REG_BAR_START: cfg_bar_start = longint'(signed'(v));
            REG_BAR_END:   cfg_bar_end = longint'(signed'(v));
            REG_KF_RANGE:  cfg_kf_range = longint'(v[30:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] sd, logic [31:0] per, logic kf,
                              logic [31:0] bs, logic [31:0] be, logic [31:0] kr);
        drain();
        write_reg(REG_SNAP_DIST, sd);
        write_reg(REG_PERIOD, per);
        write_reg(REG_KF_MODE, {31'd0, kf});
        write_reg(REG_BAR_START, bs);
        write_reg(REG_BAR_END, be);
        write_reg(REG_KF_RANGE, kr);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(2000) - 1000;
            2: return {1'($urandom_range(1)), 31'd0} + 32'($urandom_range(3)) - 32'd1;
            default: return $urandom_range(200);
        endcase
    endfunction

    task automatic test_directed;
        set_config(32'd100, 32'd0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(CMD_QUERY, 32'd5, 1'b1);          // empty table
        send_request(CMD_QUERY, 32'h8000_0000, 1'b0);  // bar start exact
        send_request(CMD_QUERY, 32'd0, 1'b0);          // bar end nearer by one
        send_request(CMD_ADD, 32'h7FFF_FFFF, 1'b0);
        send_request(CMD_ADD, 32'h8000_0000, 1'b1);
        send_request(CMD_ADD, 32'd50, 1'b0);
        send_request(CMD_ADD, 32'd50, 1'b0);           // duplicate
        send_request(CMD_NONE, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_QUERY, 32'h7FFF_FFFF, 1'b1);  // equal to largest stored
        send_request(CMD_QUERY, 32'h8000_0000, 1'b1);
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0);
        send_request(CMD_QUERY, 32'h7FFF_FFF0, 1'b1);  // periodic high point at max
        send_request(CMD_QUERY, 32'hC000_0000, 1'b1);  // negative truncation
        send_request(CMD_QUERY, 32'd25, 1'b0);
        send_request(CMD_CLEAR, 32'd0, 1'b0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(CMD_ADD, 32'(i * 10), 1'b0);
        send_request(CMD_ADD, 32'd5, 1'b0);            // full, dropped
        send_request(CMD_ADD, 32'd20, 1'b0);           // full duplicate
        send_request(CMD_QUERY, 32'd9999, 1'b1);
        send_request(CMD_CLEAR, 32'd0, 1'b0);
    endtask

    task automatic test_random(int n);
        t_cmd cmd;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            cmd = (r < 40) ? CMD_ADD : (r < 44) ? CMD_CLEAR : (r < 97) ? CMD_QUERY : CMD_NONE;
            send_request(cmd, rand_time(), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_settings;
        set_config(32'd30, 32'd100, 1'b1, 32'hFFFF_FF00, 32'd300, 32'd60);
        send_idle_pct = 30; recv_stall_pct = 66;
        test_random(180);
        set_config($urandom, $urandom | 32'd1, 1'b1, $urandom, $urandom, $urandom);
        send_idle_pct = 66; recv_stall_pct = 30;
        test_random(180);
        set_config(32'd0, 32'd1, 1'b0, 32'd0, 32'd0, 32'd0);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(60);
        set_config(32'd500, 32'd7, 1'b1, 32'd100, 32'hFFFF_FF9C, 32'd400);
        test_random(50);
    endtask

    initial begin
        cfg_snap_dist = 0; cfg_period = 64'd2147483647; cfg_kf_mode = 0;
        cfg_bar_start = 0; cfg_bar_end = 0; cfg_kf_range = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_settings();
        drain();
        $display("covered %0d results, %0d queries, %0d snaps, %0d dropped adds",
                 results_seen, queries_sent, snaps_seen, drops_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
